/* design/ckht_pkg.sv */
// Shared types and command/status codes for the coordinate hash table.
package ckht_pkg;

  localparam logic [2:0] CMD_PUT     = 3'd0;
  localparam logic [2:0] CMD_RM_HDL  = 3'd1;
  localparam logic [2:0] CMD_RM_KEY  = 3'd2;
  localparam logic [2:0] CMD_GET     = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] key_x;
    logic [31:0] key_z;
    logic [31:0] value_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_handle;
  } rsp_t;

endpackage

/* design/coordinate_keyed_chained_hash_table.sv */
// Top level: coordinate-keyed hash table with chained buckets in a fixed pool.
//
// Usage:
//  - Request channel (req_valid_i / req_stall_o / req_i) carries one command:
//    put, remove by handle, remove by key, get, or clear.
//  - Response channel (rsp_valid_o / rsp_stall_i / rsp_o) returns exactly one
//    status/handle pair per request, in request order.
//  - One request is in flight at a time. Each chain step is one read of the
//    entry memory plus a compare. A put walks to the tail of its chain; a put
//    on a full pool and an unknown command are answered without a walk. Clear
//    sweeps the link and head memories one entry a cycle. The next request
//    can be taken in the cycle after the response is loaded.
//  - After reset the block runs the same sweep to build the free list and
//    empty the bucket heads; req_stall_o is high meanwhile and no response
//    comes out.
//  - A finished response sits in an output register; the next request is
//    taken while it waits, and the engine holds only if a second response
//    would have to be written while the first is still stalled.
//  - Key and handle memories are undefined until written; they are only read
//    through chains, which hold written entries only.
module coordinate_keyed_chained_hash_table #(
  parameter int HASH_SIDE    = 16,
  parameter int POOL_ENTRIES = 1024,
  parameter int HANDLE_BITS  = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_stall_o,
  input  ckht_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_stall_i,
  output ckht_pkg::rsp_t  rsp_o
);
  localparam int SB    = (HASH_SIDE > 1) ? $clog2(HASH_SIDE) : 1;
  localparam int NB    = HASH_SIDE * HASH_SIDE;
  localparam int BB    = $clog2(NB);
  localparam int PB    = $clog2(POOL_ENTRIES + 1);  // link width incl. NIL
  localparam int IB    = $clog2(POOL_ENTRIES);
  localparam int HB    = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam int SWEEP = (POOL_ENTRIES > NB) ? POOL_ENTRIES : NB;
  localparam int WB    = $clog2(SWEEP + 1);
  localparam logic [PB-1:0] NIL = PB'(POOL_ENTRIES);

  typedef enum logic [8:0] {
    S_SWEEP = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HEAD  = 9'b000000100,
    S_LOOK  = 9'b000001000,
    S_ENT   = 9'b000010000,
    S_FREE  = 9'b000100000,
    S_FLINK = 9'b001000000,
    S_RESP  = 9'b010000000,
    S_FHEAD = 9'b100000000
  } state_e;

  // memories
  logic [PB-1:0] heads_mem [NB];
  logic [63:0]   keys_mem  [POOL_ENTRIES];
  logic [HB-1:0] vals_mem  [POOL_ENTRIES];
  logic [PB-1:0] links_mem [POOL_ENTRIES];

  logic          h_we; logic [BB-1:0] h_wa; logic [PB-1:0] h_wd; logic [PB-1:0] h_rd;
  logic          l_we; logic [IB-1:0] l_wa; logic [PB-1:0] l_wd;
  logic [IB-1:0] e_ra; logic [PB-1:0] l_rd; logic [63:0] k_rd; logic [HB-1:0] v_rd;
  logic          kv_we;

  state_e state_q, state_d;
  ckht_pkg::req_t req_q;
  logic [BB-1:0] bkt_q;
  logic [PB-1:0] cur_q, cur_d, prev_q, prev_d, free_q, free_d, nxt_q, nxt_d;
  logic [WB-1:0] cnt_q, cnt_d;
  logic [1:0]    st_q, st_d;
  logic [31:0]   fh_q, fh_d;
  logic          hit_q, hit_d;
  logic          load;
  logic          out_busy;
  ckht_pkg::rsp_t rsp_n;

  logic [BB-1:0] bkt_in;
  logic [SB-1:0] xm, zm;
  assign xm = SB'(req_i.key_x % HASH_SIDE);
  assign zm = SB'(req_i.key_z % HASH_SIDE);
  assign bkt_in = BB'(xm) + BB'(zm) * BB'(HASH_SIDE);

  always_ff @(posedge clk_i) begin
    if (h_we) heads_mem[h_wa] <= h_wd;
    h_rd <= heads_mem[bkt_q];
    if (l_we) links_mem[l_wa] <= l_wd;
    if (kv_we) begin
      keys_mem[cur_q[IB-1:0]] <= {req_q.key_z, req_q.key_x};
      vals_mem[cur_q[IB-1:0]] <= HB'(req_q.value_handle);
    end
    l_rd <= links_mem[e_ra];
    k_rd <= keys_mem[e_ra];
    v_rd <= vals_mem[e_ra];
  end

  logic match;
  assign match = (req_q.cmd == ckht_pkg::CMD_RM_HDL) ?
                 (v_rd == HB'(req_q.value_handle)) :
                 (k_rd == {req_q.key_z, req_q.key_x});

  always_comb begin
    state_d = state_q; cur_d = cur_q; prev_d = prev_q; free_d = free_q;
    nxt_d = nxt_q; cnt_d = cnt_q; st_d = st_q; fh_d = fh_q; hit_d = hit_q;
    h_we = 1'b0; h_wa = bkt_q; h_wd = NIL;
    l_we = 1'b0; l_wa = cur_q[IB-1:0]; l_wd = NIL;
    kv_we = 1'b0; e_ra = cur_q[IB-1:0]; load = 1'b0;
    unique case (state_q)
      S_SWEEP: begin
        if (cnt_q < WB'(NB)) begin
          h_we = 1'b1; h_wa = cnt_q[BB-1:0];
        end
        if (cnt_q < WB'(POOL_ENTRIES)) begin
          l_we = 1'b1; l_wa = cnt_q[IB-1:0]; l_wd = PB'(cnt_q) + PB'(1);
        end
        cnt_d = cnt_q + WB'(1);
        if (cnt_q == WB'(SWEEP - 1)) begin
          free_d = '0; st_d = ckht_pkg::ST_DONE; fh_d = '0; state_d = S_RESP;
        end
      end
      S_IDLE: ;
      S_HEAD: state_d = S_LOOK;   // head read in flight
      S_LOOK: begin
        prev_d = NIL; cur_d = h_rd; cnt_d = '0; st_d = ckht_pkg::ST_MISS; fh_d = '0;
        hit_d = 1'b0;
        if (req_q.cmd == ckht_pkg::CMD_PUT) begin
          if (free_q == NIL) begin
            st_d = ckht_pkg::ST_FULL; state_d = S_RESP;
          end else begin
            st_d = ckht_pkg::ST_DONE;
            cur_d = free_q; nxt_d = h_rd; state_d = S_FREE;  // read free link
          end
        end else if (h_rd == NIL) state_d = S_RESP;
        else state_d = S_ENT;
      end
      // put: free_q popped after reading its link; then walk to tail.
      S_FREE: state_d = S_FLINK;
      S_FLINK: begin
        free_d = l_rd; kv_we = 1'b1; l_we = 1'b1; l_wd = NIL;
        hit_d = 1'b1;  // remembers new entry in prev for tail append
        prev_d = cur_q;
        if (nxt_q == NIL) begin
          h_we = 1'b1; h_wd = cur_q; state_d = S_RESP;
        end else begin
          cur_d = nxt_q; state_d = S_ENT;
        end
      end
      S_ENT: state_d = S_FHEAD;   // entry read in flight
      S_FHEAD: begin
        cnt_d = cnt_q + WB'(1);
        if (req_q.cmd == ckht_pkg::CMD_PUT) begin
          if (l_rd == NIL || cnt_q == WB'(POOL_ENTRIES - 1)) begin
            l_we = 1'b1; l_wd = prev_q; state_d = S_RESP;
          end else begin
            cur_d = l_rd; state_d = S_ENT;
          end
        end else if (match) begin
          st_d = ckht_pkg::ST_DONE; state_d = S_RESP;
          if (req_q.cmd == ckht_pkg::CMD_GET) fh_d = 32'(v_rd);
          else begin
            if (prev_q == NIL) begin
              h_we = 1'b1; h_wd = l_rd;
            end else begin
              l_we = 1'b1; l_wa = prev_q[IB-1:0]; l_wd = l_rd;
            end
            hit_d = 1'b1; nxt_d = free_q; free_d = cur_q;
          end
        end else if (l_rd == NIL || cnt_q == WB'(POOL_ENTRIES - 1)) begin
          state_d = S_RESP;
        end else begin
          prev_d = cur_q; cur_d = l_rd; state_d = S_ENT;
        end
      end
      S_RESP: begin
        // finish unlink: freed entry points at old free head
        if (hit_q && req_q.cmd != ckht_pkg::CMD_PUT) begin
          l_we = 1'b1; l_wd = nxt_q;
        end
        if (!out_busy) begin
          load = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_FHEAD && req_q.cmd == ckht_pkg::CMD_PUT &&
        (l_rd == NIL || cnt_q == WB'(POOL_ENTRIES - 1))) begin
      l_wa = cur_q[IB-1:0];
    end
    if (state_q == S_IDLE && req_valid_i) begin
      hit_d = 1'b0;
      priority if (req_i.cmd == ckht_pkg::CMD_CLEAR) begin
        cnt_d = '0; state_d = S_SWEEP;
      end else if (req_i.cmd > ckht_pkg::CMD_CLEAR) begin
        st_d = ckht_pkg::ST_DONE; fh_d = '0; state_d = S_RESP;
      end else state_d = S_HEAD;
    end
  end

  // put tail append writes new entry index into the tail's link
  logic unused_ok;
  assign unused_ok = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP; cnt_q <= '0; free_q <= '0; hit_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; free_q <= free_d; hit_q <= hit_d;
    end
  end

  // reset sweep also produces no response
  logic boot_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) boot_q <= 1'b1;
    else if (state_q == S_RESP) boot_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; prev_q <= prev_d; nxt_q <= nxt_d; st_q <= st_d; fh_q <= fh_d;
    if (state_q == S_IDLE && req_valid_i) begin
      req_q <= req_i; bkt_q <= bkt_in;
    end
  end

  assign rsp_n.status = st_q;
  assign rsp_n.found_handle = fh_q;

  ckht_out_reg u_out (
    .clk_i, .rst_ni,
    .load_i (load && !boot_q && unused_ok),
    .rsp_i  (rsp_n),
    .busy_o (out_busy),
    .valid_o(rsp_valid_o),
    .stall_i(rsp_stall_i),
    .rsp_o
  );

  assign req_stall_o = (state_q != S_IDLE);

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && !req_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted request did not start");
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= NIL) else $error("free head out of range");
endmodule

/* design/ckht_out_reg.sv */
// One-entry output register holding a response until the receiver takes it.
module ckht_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ckht_pkg::rsp_t rsp_i,
  output logic          busy_o,
  output logic          valid_o,
  input  logic          stall_i,
  output ckht_pkg::rsp_t rsp_o
);
  logic valid_q, valid_d;
  ckht_pkg::rsp_t rsp_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !stall_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) rsp_q <= rsp_i;
  end

  assign busy_o  = valid_q && stall_i;
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;
endmodule
